// ===== src/klk_pkg.sv =====
// package: shared types, constants and helper functions of the keyed group tuple lookup
`default_nettype none
package klk_pkg;

  // default sizing of the top level
  localparam int MAX_GROUP_LEN_DEF = 1024;
  localparam int TUPLE_LEN_MAX_DEF = 16;

  // field widths
  localparam int BLK_W   = 14;
  localparam int GIDX_W  = 4;
  localparam int TOTAL_W = 15;
  localparam int GCNT_W  = 5;
  localparam int KEY_W   = 64;
  localparam int CFG_IDX_W = 2;

  // stored shuffle entry width, holds group*len + i for any group up to the block range
  localparam int PW = 15;

  // serial divider sizing
  localparam int DIVW      = 16;
  localparam int DIV_STEPS = 64;

  // double dabble of a block-sized group id into five decimal digits
  localparam int BCD_DIGITS = 5;
  localparam int BCD_STEPS  = BLK_W;

  // message layout
  localparam int HEX_CHARS = 32;
  localparam logic [7:0] ASCII_COLON = 8'h3a;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_HEXA  = 8'h57;
  localparam logic [7:0] MSG_PAD     = 8'h80;

  // xorshift64 shifts
  localparam int XS_A = 13;
  localparam int XS_B = 7;
  localparam int XS_C = 17;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_HIGH     = 2'd0,
    CFG_KEY_LOW      = 2'd1,
    CFG_TOTAL_BLOCKS = 2'd2,
    CFG_GROUP_COUNT  = 2'd3
  } cfg_idx_e;

  // result status codes
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_NO_TUPLE = 1'b1;

  localparam logic [31:0] SHA_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DIVM_GO,
    S_DIVM_WAIT,
    S_MCHK,
    S_DIVG_WAIT,
    S_ERR,
    S_BCD_GO,
    S_BCD_WAIT,
    S_SHA_WAIT,
    S_FILL,
    S_XS,
    S_MOD_WAIT,
    S_RDI,
    S_RDJ,
    S_WRI,
    S_WRJ,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_OUT_RD,
    S_OUT_PUT
  } klk_state_e;

  // divider operand select
  typedef enum logic [1:0] {
    DIV_M,
    DIV_G,
    DIV_X
  } div_src_e;

  // shuffle store read address select
  typedef enum logic [1:0] {
    ADDR_IDX,
    ADDR_J,
    ADDR_FOUND
  } addr_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic      in_ready;
    logic      div_start;
    div_src_e  div_src;
    logic      latch_m;
    logic      latch_gid;
    logic      use_g;
    logic      bcd_start;
    logic      sha_start;
    logic      seed_load;
    logic      idx_clr;
    logic      idx_top;
    logic      idx_inc;
    logic      idx_dec;
    logic      fill_wr;
    logic      xs_step;
    logic      latch_j;
    addr_sel_e addr_sel;
    logic      latch_ti;
    logic      wr_i;
    logic      wr_j;
    logic      found_set;
    logic      found_clr;
    logic      g_clr;
    logic      g_inc;
    logic      out_ok;
    logic      out_err;
  } klk_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic bcd_busy;
    logic sha_busy;
    logic m_zero;
    logic m_one;
    logic idx_last;
    logic idx_one;
    logic hit;
    logic g_last;
    logic out_free;
  } klk_stat_t;

  function automatic logic [31:0] rotr32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [63:0] xorshift64(logic [63:0] x);
    logic [63:0] y;
    y = x ^ (x << XS_A);
    y = y ^ (y >> XS_B);
    y = y ^ (y << XS_C);
    return y;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) begin
      return ASCII_ZERO + 8'(n);
    end
    return ASCII_HEXA + 8'(n);
  endfunction

endpackage
`default_nettype wire

// ===== src/klk_cfg_if.sv =====
// interface: configuration write channel
`default_nettype none
interface klk_cfg_if import klk_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [KEY_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/klk_in_if.sv =====
// interface: block request channel
`default_nettype none
interface klk_in_if import klk_pkg::*;;
  logic             valid;
  logic             ready;
  logic [BLK_W-1:0] block_number;

  modport source (output valid, output block_number, input ready);
  modport sink (input valid, input block_number, output ready);
endinterface
`default_nettype wire

// ===== src/klk_out_if.sv =====
// interface: tuple member result channel
`default_nettype none
interface klk_out_if import klk_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BLK_W-1:0]  member;
  logic [GIDX_W-1:0] group_index;
  logic              last;
  logic              status;

  modport source (output valid, output member, output group_index, output last,
                  output status, input ready);
  modport sink (input valid, input member, input group_index, input last,
                input status, output ready);
endinterface
`default_nettype wire

// ===== src/klk_div.sv =====
// module: bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module klk_div import klk_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [63:0]     dividend_i,
  input  logic [DIVW-1:0] divisor_i,
  output logic            busy_o,
  output logic [63:0]     quot_o,
  output logic [DIVW-1:0] rem_o
);

  localparam int CNTW = $clog2(DIV_STEPS + 1);

  logic            busy_q, busy_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [63:0]     quot_q, quot_d;
  logic [DIVW-1:0] rem_q, rem_d;
  logic [DIVW-1:0] dvs_q, dvs_d;
  logic [DIVW:0]   rem_sh;
  logic [DIVW:0]   rem_sub;
  logic            ge;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_q, quot_q[63]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[62:0], ge};
      rem_d  = ge ? rem_sub[DIVW-1:0] : rem_sh[DIVW-1:0];
      cnt_d  = cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== src/klk_sha.sv =====
// module: single-block sha-256 engine, one round per cycle, gives the first 64 digest bits
`default_nettype none
module klk_sha import klk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [15:0][31:0] msg_i,
  output logic             busy_o,
  output logic [63:0]      digest_o
);

  logic        busy_q, busy_d;
  logic [5:0]  t_q, t_d;
  logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
  logic [31:0] w_q [16];
  logic [31:0] s0, s1, ch, mj, t1, t2, ws0, ws1, w_new;

  // round and schedule logic
  always_comb begin
    s1    = rotr32(e_q, 6) ^ rotr32(e_q, 11) ^ rotr32(e_q, 25);
    ch    = (e_q & f_q) ^ (~e_q & g_q);
    t1    = h_q + s1 + ch + SHA_K[t_q] + w_q[0];
    s0    = rotr32(a_q, 2) ^ rotr32(a_q, 13) ^ rotr32(a_q, 22);
    mj    = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
    t2    = s0 + mj;
    ws0   = rotr32(w_q[1], 7) ^ rotr32(w_q[1], 18) ^ (w_q[1] >> 3);
    ws1   = rotr32(w_q[14], 17) ^ rotr32(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_q[0] + ws0 + w_q[9] + ws1;
    busy_d = busy_q;
    t_d    = t_q;
    if (start_i) begin
      busy_d = 1'b1;
      t_d    = '0;
    end else if (busy_q) begin
      t_d = t_q + 6'd1;
      if (t_q == 6'd63) begin
        busy_d = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      t_q    <= '0;
    end else begin
      busy_q <= busy_d;
      t_q    <= t_d;
    end
  end

  // working variables and message window
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= SHA_INIT[0];
      b_q <= SHA_INIT[1];
      c_q <= SHA_INIT[2];
      d_q <= SHA_INIT[3];
      e_q <= SHA_INIT[4];
      f_q <= SHA_INIT[5];
      g_q <= SHA_INIT[6];
      h_q <= SHA_INIT[7];
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= msg_i[15-i];
      end
    end else if (busy_q) begin
      h_q <= g_q;
      g_q <= f_q;
      f_q <= e_q;
      e_q <= d_q + t1;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= a_q;
      a_q <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
    end
  end

  assign busy_o   = busy_q;
  assign digest_o = {SHA_INIT[0] + a_q, SHA_INIT[1] + b_q};

endmodule
`default_nettype wire

// ===== src/klk_datapath.sv =====
// module: datapath with config registers, divider, hash, shuffle store and result register
`default_nettype none
module klk_datapath import klk_pkg::*; #(
  parameter int MAX_GROUP_LEN = MAX_GROUP_LEN_DEF,
  parameter int TUPLE_LEN_MAX = TUPLE_LEN_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  klk_cfg_if.sink   cfg_i,
  klk_in_if.sink    req_i,
  klk_out_if.source rsp_o,
  input  klk_cmd_t  cmd_i,
  output klk_stat_t stat_o
);

  localparam int IW = $clog2(MAX_GROUP_LEN);
  localparam int MW = $clog2(MAX_GROUP_LEN + 1);
  localparam int CW = $clog2(TUPLE_LEN_MAX + 1);
  localparam int BCW = $clog2(BCD_STEPS);

  // configuration registers
  logic [KEY_W-1:0]   kh_q, kl_q;
  logic [TOTAL_W-1:0] total_q;
  logic [GCNT_W-1:0]  gcnt_q;

  // item registers
  logic [BLK_W-1:0] block_q;
  logic [CW-1:0]    cnt_q;
  logic [MW-1:0]    m_q;
  logic [BLK_W-1:0] gid_q;
  logic [CW-1:0]    g_q;
  logic [IW-1:0]    idx_q, j_q, found_q;
  logic [PW-1:0]    ti_q, base_q, rdata_q;
  logic [63:0]      rng_q;

  // decimal conversion
  logic             bbusy_q;
  logic [BCW-1:0]   bcnt_q;
  logic [BLK_W-1:0] bsrc_q;
  logic [4*BCD_DIGITS-1:0] bcd_q, bcd_adj;

  // result register
  logic              ovalid_q;
  logic [BLK_W-1:0]  omember_q;
  logic [GIDX_W-1:0] ogidx_q;
  logic              olast_q, ostat_q;

  logic [BLK_W-1:0]     sg;
  logic [BLK_W+MW-1:0]  prod;
  logic [63:0]          xs_val;
  logic [63:0]          dv_dividend;
  logic [DIVW-1:0]      dv_divisor;
  logic                 dv_busy;
  logic [63:0]          dv_quot;
  logic [DIVW-1:0]      dv_rem;
  logic                 sha_busy;
  logic [63:0]          digest;
  logic [15:0][31:0]    msg;
  logic [2:0]           nd;
  logic                 in_acc;
  logic                 mem_we;
  logic [IW-1:0]        waddr, raddr;
  logic [PW-1:0]        wdata;
  logic [PW-1:0]        perm_mem [MAX_GROUP_LEN];

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = cmd_i.in_ready;
  assign in_acc      = req_i.valid && cmd_i.in_ready;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kh_q    <= '0;
      kl_q    <= '0;
      total_q <= TOTAL_W'(1024);
      gcnt_q  <= GCNT_W'(1);
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_KEY_HIGH:     kh_q    <= cfg_i.data;
        CFG_KEY_LOW:      kl_q    <= cfg_i.data;
        CFG_TOTAL_BLOCKS: total_q <= cfg_i.data[TOTAL_W-1:0];
        CFG_GROUP_COUNT:  gcnt_q  <= cfg_i.data[GCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // group being shuffled and its base value
  assign sg     = cmd_i.use_g ? BLK_W'(g_q) : gid_q;
  assign prod   = (BLK_W+MW)'(sg) * (BLK_W+MW)'(m_q);
  assign xs_val = xorshift64(rng_q);

  // divider operand select
  always_comb begin
    case (cmd_i.div_src)
      DIV_M: begin
        dv_dividend = 64'(total_q);
        dv_divisor  = DIVW'(cnt_q);
      end
      DIV_G: begin
        dv_dividend = 64'(block_q);
        dv_divisor  = DIVW'(m_q);
      end
      default: begin
        dv_dividend = xs_val;
        dv_divisor  = DIVW'(idx_q) + DIVW'(1);
      end
    endcase
  end

  klk_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dv_dividend),
    .divisor_i  (dv_divisor),
    .busy_o     (dv_busy),
    .quot_o     (dv_quot),
    .rem_o      (dv_rem)
  );

  // number of significant decimal digits of the group id
  always_comb begin
    nd = 3'd1;
    for (int k = 1; k < BCD_DIGITS; k++) begin
      if (bcd_q[4*k +: 4] != 4'd0) begin
        nd = 3'(k + 1);
      end
    end
  end

  // hash message: hex key, colon, decimal group id, padding, bit length
  always_comb begin
    logic [7:0]   mb [64];
    logic [127:0] key;
    logic [15:0]  lbits;
    int           di;
    key   = {kh_q, kl_q};
    lbits = 16'((HEX_CHARS + 1 + int'(nd)) * 8);
    di    = 0;
    for (int b = 0; b < 64; b++) begin
      mb[b] = 8'h00;
      if (b < HEX_CHARS) begin
        mb[b] = hex_char(key[127-4*b -: 4]);
      end else if (b == HEX_CHARS) begin
        mb[b] = ASCII_COLON;
      end else if (b < HEX_CHARS + 1 + int'(nd)) begin
        di    = int'(nd) - 1 - (b - HEX_CHARS - 1);
        mb[b] = ASCII_ZERO + 8'(4'(bcd_q >> (4 * di)));
      end else if (b == HEX_CHARS + 1 + int'(nd)) begin
        mb[b] = MSG_PAD;
      end else if (b == 62) begin
        mb[b] = lbits[15:8];
      end else if (b == 63) begin
        mb[b] = lbits[7:0];
      end
    end
    for (int w = 0; w < 16; w++) begin
      msg[15-w] = {mb[4*w], mb[4*w+1], mb[4*w+2], mb[4*w+3]};
    end
  end

  klk_sha u_sha (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.sha_start),
    .msg_i    (msg),
    .busy_o   (sha_busy),
    .digest_o (digest)
  );

  // double dabble adjust
  always_comb begin
    bcd_adj = bcd_q;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bbusy_q  <= 1'b0;
      bcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.bcd_start) begin
        bbusy_q <= 1'b1;
        bcnt_q  <= '0;
      end else if (bbusy_q) begin
        bcnt_q <= bcnt_q + BCW'(1);
        if (bcnt_q == BCW'(BCD_STEPS - 1)) begin
          bbusy_q <= 1'b0;
        end
      end
      if (cmd_i.out_ok || cmd_i.out_err) begin
        ovalid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // item, counter and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      block_q <= req_i.block_number;
      if (32'(gcnt_q) > 32'(TUPLE_LEN_MAX)) begin
        cnt_q <= CW'(TUPLE_LEN_MAX);
      end else begin
        cnt_q <= CW'(gcnt_q);
      end
    end
    if (cmd_i.latch_m) begin
      if (cnt_q == '0) begin
        m_q <= '0;
      end else if (dv_quot > 64'(MAX_GROUP_LEN)) begin
        m_q <= MW'(MAX_GROUP_LEN);
      end else begin
        m_q <= dv_quot[MW-1:0];
      end
    end
    if (cmd_i.latch_gid) begin
      gid_q <= dv_quot[BLK_W-1:0];
    end
    if (cmd_i.bcd_start) begin
      bcd_q  <= '0;
      bsrc_q <= sg;
      base_q <= prod[PW-1:0];
    end else if (bbusy_q) begin
      bcd_q  <= {bcd_adj[4*BCD_DIGITS-2:0], bsrc_q[BLK_W-1]};
      bsrc_q <= bsrc_q << 1;
    end
    if (cmd_i.seed_load) begin
      rng_q <= digest;
    end else if (cmd_i.xs_step) begin
      rng_q <= xs_val;
    end
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_top) begin
      idx_q <= IW'(m_q - MW'(1));
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IW'(1);
    end else if (cmd_i.idx_dec) begin
      idx_q <= idx_q - IW'(1);
    end
    if (cmd_i.latch_j) begin
      j_q <= dv_rem[IW-1:0];
    end
    if (cmd_i.latch_ti) begin
      ti_q <= rdata_q;
    end
    if (cmd_i.found_set) begin
      found_q <= idx_q;
    end else if (cmd_i.found_clr) begin
      found_q <= '0;
    end
    if (cmd_i.g_clr) begin
      g_q <= '0;
    end else if (cmd_i.g_inc) begin
      g_q <= g_q + CW'(1);
    end
    if (cmd_i.out_ok) begin
      omember_q <= rdata_q[BLK_W-1:0];
      ogidx_q   <= GIDX_W'(g_q);
      olast_q   <= stat_o.g_last;
      ostat_q   <= ST_OK;
    end else if (cmd_i.out_err) begin
      omember_q <= '0;
      ogidx_q   <= '0;
      olast_q   <= 1'b1;
      ostat_q   <= ST_NO_TUPLE;
    end
  end

  // shuffle store port select
  always_comb begin
    mem_we = cmd_i.fill_wr || cmd_i.wr_i || cmd_i.wr_j;
    waddr  = cmd_i.wr_j ? j_q : idx_q;
    if (cmd_i.fill_wr) begin
      wdata = base_q + PW'(idx_q);
    end else if (cmd_i.wr_i) begin
      wdata = rdata_q;
    end else begin
      wdata = ti_q;
    end
    case (cmd_i.addr_sel)
      ADDR_J:     raddr = j_q;
      ADDR_FOUND: raddr = found_q;
      default:    raddr = idx_q;
    endcase
  end

  // shuffle store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      perm_mem[waddr] <= wdata;
    end
    rdata_q <= perm_mem[raddr];
  end

  // status to controller
  always_comb begin
    stat_o.in_valid = req_i.valid;
    stat_o.div_busy = dv_busy;
    stat_o.bcd_busy = bbusy_q;
    stat_o.sha_busy = sha_busy;
    stat_o.m_zero   = m_q == '0;
    stat_o.m_one    = m_q == MW'(1);
    stat_o.idx_last = (MW'(idx_q) + MW'(1)) == m_q;
    stat_o.idx_one  = idx_q == IW'(1);
    stat_o.hit      = rdata_q == PW'(block_q);
    stat_o.g_last   = ((CW+1)'(g_q) + (CW+1)'(1)) == (CW+1)'(cnt_q);
    stat_o.out_free = !ovalid_q || rsp_o.ready;
  end

  assign rsp_o.valid       = ovalid_q;
  assign rsp_o.member      = omember_q;
  assign rsp_o.group_index = ogidx_q;
  assign rsp_o.last        = olast_q;
  assign rsp_o.status      = ostat_q;

endmodule
`default_nettype wire

// ===== src/klk_ctrl.sv =====
// module: controller state machine sequencing division, hashing, shuffle, search and output
`default_nettype none
module klk_ctrl import klk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  klk_stat_t stat_i,
  output klk_cmd_t  cmd_o
);

  klk_state_e st_q, st_d;
  logic       emit_q, emit_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      emit_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      emit_q <= emit_d;
    end
  end

  // next state and commands
  always_comb begin
    st_d   = st_q;
    emit_d = emit_q;
    cmd_o  = '0;
    cmd_o.div_src  = DIV_X;
    cmd_o.addr_sel = ADDR_IDX;
    cmd_o.use_g    = emit_q;
    case (st_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          st_d = S_DIVM_GO;
        end
      end
      S_DIVM_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = DIV_M;
        st_d = S_DIVM_WAIT;
      end
      S_DIVM_WAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.latch_m = 1'b1;
          st_d = S_MCHK;
        end
      end
      S_MCHK: begin
        if (stat_i.m_zero) begin
          st_d = S_ERR;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = DIV_G;
          st_d = S_DIVG_WAIT;
        end
      end
      S_DIVG_WAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.latch_gid = 1'b1;
          emit_d = 1'b0;
          st_d   = S_BCD_GO;
        end
      end
      S_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.out_err = 1'b1;
          st_d = S_IDLE;
        end
      end
      S_BCD_GO: begin
        cmd_o.bcd_start = 1'b1;
        st_d = S_BCD_WAIT;
      end
      S_BCD_WAIT: begin
        if (!stat_i.bcd_busy) begin
          cmd_o.sha_start = 1'b1;
          st_d = S_SHA_WAIT;
        end
      end
      S_SHA_WAIT: begin
        if (!stat_i.sha_busy) begin
          cmd_o.seed_load = 1'b1;
          cmd_o.idx_clr   = 1'b1;
          st_d = S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (stat_i.idx_last) begin
          cmd_o.idx_top = 1'b1;
          if (stat_i.m_one) begin
            if (emit_q) begin
              st_d = S_OUT_RD;
            end else begin
              st_d = S_SCAN_RD;
            end
          end else begin
            st_d = S_XS;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_XS: begin
        cmd_o.xs_step   = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = DIV_X;
        st_d = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.latch_j = 1'b1;
          st_d = S_RDI;
        end
      end
      S_RDI: begin
        cmd_o.addr_sel = ADDR_IDX;
        st_d = S_RDJ;
      end
      S_RDJ: begin
        cmd_o.addr_sel = ADDR_J;
        cmd_o.latch_ti = 1'b1;
        st_d = S_WRI;
      end
      S_WRI: begin
        cmd_o.wr_i = 1'b1;
        st_d = S_WRJ;
      end
      S_WRJ: begin
        cmd_o.wr_j = 1'b1;
        if (stat_i.idx_one) begin
          if (emit_q) begin
            st_d = S_OUT_RD;
          end else begin
            cmd_o.idx_clr = 1'b1;
            st_d = S_SCAN_RD;
          end
        end else begin
          cmd_o.idx_dec = 1'b1;
          st_d = S_XS;
        end
      end
      S_SCAN_RD: begin
        cmd_o.addr_sel = ADDR_IDX;
        st_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat_i.hit) begin
          cmd_o.found_set = 1'b1;
          cmd_o.g_clr     = 1'b1;
          emit_d = 1'b1;
          st_d   = S_BCD_GO;
        end else if (stat_i.idx_last) begin
          cmd_o.found_clr = 1'b1;
          cmd_o.g_clr     = 1'b1;
          emit_d = 1'b1;
          st_d   = S_BCD_GO;
        end else begin
          cmd_o.idx_inc = 1'b1;
          st_d = S_SCAN_RD;
        end
      end
      S_OUT_RD: begin
        cmd_o.addr_sel = ADDR_FOUND;
        st_d = S_OUT_PUT;
      end
      S_OUT_PUT: begin
        cmd_o.addr_sel = ADDR_FOUND;
        if (stat_i.out_free) begin
          cmd_o.out_ok = 1'b1;
          if (stat_i.g_last) begin
            st_d = S_IDLE;
          end else begin
            cmd_o.g_inc = 1'b1;
            st_d = S_BCD_GO;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/keyed_group_tuple_lookup_core.sv =====
// top level: keyed group tuple lookup core
//
//   channel  dir  transaction              payload
//   cfg_i    in   register write           index, data
//   req_i    in   block request            block_number
//   rsp_o    out  one tuple member         member, group_index, last, status
//
// one request at a time; two 64-step divides, then (count+1) shuffles of m
// entries, one for the request's own group and one per tuple member, with a
// search of up to m entries after the first; the 64-step serial modulo of every
// swap dominates the run time
// reset clears control state and sets the config registers to zero key, 1024 blocks, one group;
// the shuffle store needs no clearing; a result waits in the output register while the next member is computed;
// a stalled output holds the engine only when the next member is ready
`default_nettype none
module keyed_group_tuple_lookup_core import klk_pkg::*; #(
  parameter int MAX_GROUP_LEN = MAX_GROUP_LEN_DEF,
  parameter int TUPLE_LEN_MAX = TUPLE_LEN_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  klk_cfg_if.sink   cfg_i,
  klk_in_if.sink    req_i,
  klk_out_if.source rsp_o
);

  klk_cmd_t  cmd;
  klk_stat_t stat;

  klk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  klk_datapath #(
    .MAX_GROUP_LEN (MAX_GROUP_LEN),
    .TUPLE_LEN_MAX (TUPLE_LEN_MAX)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule
`default_nettype wire

// ===== tb/klk_tb_top.sv =====
// testbench: checks the keyed group tuple lookup core against a built-in tuple predictor
`default_nettype none
module testbench;
  import klk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 600000;

  typedef struct {
    logic [BLK_W-1:0]  member;
    logic [GIDX_W-1:0] group_index;
    logic              last;
    logic              status;
  } tuple_member_t;

  typedef int perm_t[];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  klk_cfg_if cfg ();
  klk_in_if  req ();
  klk_out_if rsp ();

  keyed_group_tuple_lookup_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .req_i (req),
    .rsp_o (rsp)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the configuration
  logic [63:0] key_hi = '0;
  logic [63:0] key_lo = '0;
  int unsigned total_cfg = 1024;
  int unsigned count_cfg = 1;

  logic [BLK_W-1:0] block_queue[$];
  tuple_member_t    tuple_queue[$];
  int errors = 0;
  int blocks_sent = 0;
  int members_seen = 0;
  int hold_cycles = 0;
  bit req_fired = 1'b0;
  bit rsp_fired = 1'b0;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // first 64 bits of the sha-256 digest of one padded block
  function automatic logic [63:0] sha_head(logic [7:0] blk[64]);
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2, ch, mj;
    for (int t = 0; t < 16; t++) begin
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    a = SHA_INIT[0]; b = SHA_INIT[1]; c = SHA_INIT[2]; d = SHA_INIT[3];
    e = SHA_INIT[4]; f = SHA_INIT[5]; g = SHA_INIT[6]; h = SHA_INIT[7];
    for (int t = 0; t < 64; t++) begin
      s1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
      ch = (e & f) ^ (~e & g);
      t1 = h + s1 + ch + SHA_K[t] + w[t];
      s0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
      mj = (a & b) ^ (a & c) ^ (b & c);
      t2 = s0 + mj;
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    return {SHA_INIT[0] + a, SHA_INIT[1] + b};
  endfunction

  // seed from hash of "<key hex>:<group>"
  function automatic logic [63:0] group_seed(int gid);
    logic [7:0] blk[64];
    logic [127:0] key;
    logic [3:0] nib;
    string dec;
    int len;
    logic [63:0] bits;
    key = {key_hi, key_lo};
    dec = $sformatf("%0d", gid);
    len = 0;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < 32; i++) begin
      nib = key[127 - 4*i -: 4];
      blk[len++] = (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h57 + 8'(nib);
    end
    blk[len++] = 8'h3a;
    for (int i = 0; i < dec.len(); i++) blk[len++] = dec[i];
    blk[len] = 8'h80;
    bits = 64'(len * 8);
    for (int i = 0; i < 8; i++) blk[63 - i] = bits[8*i +: 8];
    return sha_head(blk);
  endfunction

  // keyed fisher-yates shuffle of one group
  function automatic perm_t shuffle_group(int gid, int m);
    perm_t p;
    logic [63:0] x;
    int j, tmp;
    p = new[m];
    for (int i = 0; i < m; i++) p[i] = gid * m + i;
    x = group_seed(gid);
    for (int i = m - 1; i > 0; i--) begin
      x = x ^ (x << 13);
      x = x ^ (x >> 7);
      x = x ^ (x << 17);
      j = int'(x % (64'(i) + 64'd1));
      tmp = p[i]; p[i] = p[j]; p[j] = tmp;
    end
    return p;
  endfunction

  // expected tuple members for one block request
  function automatic void predict_tuple(logic [BLK_W-1:0] blk);
    int unsigned cnt, m;
    int pos;
    perm_t p;
    tuple_member_t r;
    cnt = (count_cfg > TUPLE_LEN_MAX_DEF) ? TUPLE_LEN_MAX_DEF : count_cfg;
    m = (cnt == 0) ? 0 : total_cfg / cnt;
    if (m == 0) begin
      r = '{member: '0, group_index: '0, last: 1'b1, status: ST_NO_TUPLE};
      tuple_queue.push_back(r);
      return;
    end
    if (m > MAX_GROUP_LEN_DEF) m = MAX_GROUP_LEN_DEF;
    p = shuffle_group(int'(blk) / m, m);
    pos = 0;
    for (int i = 0; i < m; i++) begin
      if (p[i] == blk) begin
        pos = i;
        break;
      end
    end
    for (int g = 0; g < cnt; g++) begin
      p = shuffle_group(g, m);
      r.member = p[pos][BLK_W-1:0];
      r.group_index = g[GIDX_W-1:0];
      r.last = (g + 1 == cnt);
      r.status = ST_OK;
      tuple_queue.push_back(r);
    end
  endfunction

  // request handshake and prediction at the rising edge
  always @(posedge clk_i) begin
    req_fired = req.valid && req.ready;
    if (req_fired) begin
      predict_tuple(req.block_number);
      blocks_sent++;
    end
  end

  // request driver
  int req_gap = 0;
  always @(negedge clk_i) begin
    logic nv;
    nv = req.valid;
    if (!rst_ni) begin
      nv = 1'b0;
    end else begin
      if (req.valid && req_fired) begin
        nv = 1'b0;
        req_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
      end
      if (!nv) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (block_queue.size() > 0) begin
          req.block_number <= block_queue.pop_front();
          nv = 1'b1;
        end
      end
    end
    req.valid <= nv;
  end

  // result receiver with random stalls and long hold-off
  int rsp_wait = 0;
  always @(negedge clk_i) begin
    if (rsp_fired) rsp_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
    if (hold_cycles > 0) begin
      hold_cycles--;
      rsp.ready <= 1'b0;
    end else if (rsp_wait > 0) begin
      rsp_wait--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // result monitor and watchdog
  int idle_count = 0;
  always @(posedge clk_i) begin
    tuple_member_t e;
    rsp_fired = rsp.valid && rsp.ready;
    if (rsp_fired) begin
      members_seen++;
      if (tuple_queue.size() == 0) begin
        $error("unexpected result member=%0d group_index=%0d", rsp.member, rsp.group_index);
        errors++;
      end else begin
        e = tuple_queue.pop_front();
        if (rsp.member !== e.member) begin
          $error("member: expected %0d actual %0d", e.member, rsp.member);
          errors++;
        end
        if (rsp.group_index !== e.group_index) begin
          $error("group_index: expected %0d actual %0d", e.group_index, rsp.group_index);
          errors++;
        end
        if (rsp.last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, rsp.last);
          errors++;
        end
        if (rsp.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, rsp.status);
          errors++;
        end
      end
    end
    if (req_fired || rsp_fired || (cfg.valid && cfg.ready)) begin
      idle_count = 0;
    end else if (rst_ni) begin
      idle_count++;
      if (idle_count >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // one register write transaction
  task automatic write_reg(cfg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      CFG_KEY_HIGH:     key_hi = value;
      CFG_KEY_LOW:      key_lo = value;
      CFG_TOTAL_BLOCKS: total_cfg = 32'(value & 64'h7fff);
      default:          count_cfg = 32'(value & 64'h1f);
    endcase
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_config(logic [63:0] kh, logic [63:0] kl, int total, int count);
    write_reg(CFG_KEY_HIGH, kh);
    write_reg(CFG_KEY_LOW, kl);
    write_reg(CFG_TOTAL_BLOCKS, 64'(total));
    write_reg(CFG_GROUP_COUNT, 64'(count));
  endtask

  // wait until every request is answered and the core is quiet
  task automatic drain();
    while (block_queue.size() > 0 || req.valid || tuple_queue.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    int cnt, m, total;
    cfg.valid = 1'b0;
    cfg.index = CFG_KEY_HIGH;
    cfg.data = '0;
    req.valid = 1'b0;
    req.block_number = '0;
    rsp.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset configuration: zero key, one group of 1024
    block_queue.push_back(14'd1023);
    drain();

    // all-ones key, total of 16384, saturated group length, block past the groups
    set_config('1, '1, 16384, 1);
    block_queue.push_back(14'h3fff);
    drain();

    // zero group count and totals below the group count give no tuple
    set_config(64'h0123456789abcdef, 64'hfedcba9876543210, 100, 0);
    block_queue.push_back(14'd0);
    block_queue.push_back(14'd50);
    drain();
    set_config(64'h0123456789abcdef, 64'hfedcba9876543210, 0, 16);
    block_queue.push_back(14'd7);
    drain();
    write_reg(CFG_TOTAL_BLOCKS, 64'd5);
    write_reg(CFG_GROUP_COUNT, 64'd8);
    block_queue.push_back(14'd2);
    drain();

    // group count above the limit, blocks inside and far beyond the groups
    set_config(64'h8000000000000001, 64'h00000000ffffffff, 32, 31);
    block_queue.push_back(14'd0);
    block_queue.push_back(14'd31);
    block_queue.push_back(14'd16383);
    block_queue.push_back(14'd8192);
    block_queue.push_back(14'd21);
    drain();

    // groups of one and groups of two
    set_config(64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 16, 16);
    block_queue.push_back(14'd0);
    block_queue.push_back(14'd15);
    block_queue.push_back(14'd9999);
    drain();
    set_config(64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0, 2, 1);
    block_queue.push_back(14'd0);
    block_queue.push_back(14'd1);
    block_queue.push_back(14'd3);
    drain();

    // random phases with small groups; the first holds the receiver off
    for (int ph = 0; ph < 8; ph++) begin
      cnt = $urandom_range(1, 16);
      m = $urandom_range(1, 12);
      total = cnt * m + $urandom_range(0, cnt - 1);
      set_config({$urandom, $urandom}, {$urandom, $urandom}, total,
                 (cnt == 16 && $urandom_range(0, 1)) ? $urandom_range(16, 31) : cnt);
      if (ph == 0) hold_cycles = 20000;
      for (int k = 0; k < 12; k++) begin
        if ($urandom_range(0, 9) < 7) block_queue.push_back(14'($urandom_range(0, total - 1)));
        else block_queue.push_back(14'($urandom));
      end
      drain();
    end

    $display("ran %0d block requests over reset, extreme and random settings", blocks_sent);
    $display("checked %0d tuple members including no-tuple and saturated cases", members_seen);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
